// ----- design/fcd_pkg.sv -----
// Shared types and constants for the framed command decoder.
// Depends on nothing; used by every module of the block.
package fcd_pkg;

  // Only this many leading bytes of a frame can decide a match: the longest
  // command has five letters and the byte after it must be zero.
  localparam int unsigned PREFIX_LEN = 6;
  localparam int unsigned PREFIX_IDX_W = 3;
  localparam int unsigned NUM_CMDS = 11;
  localparam int unsigned CMD_IDX_W = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_START_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE = 2'd1;

  localparam logic [7:0] START_CODE_RST = 8'h02;
  localparam logic [7:0] END_CODE_RST = 8'h03;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_ACK  = 2'd1,
    REPLY_NAK  = 2'd2
  } reply_kind_e;

  typedef enum logic [2:0] {
    ACT_NONE         = 3'd0,
    ACT_STOP_STREAM  = 3'd1,
    ACT_SEND_ALL     = 3'd2,
    ACT_SEND_SWITCH  = 3'd3,
    ACT_SEND_LIGHT   = 3'd4,
    ACT_START_STREAM = 3'd5,
    ACT_SET_INTERVAL = 3'd6
  } action_e;

  // Byte i of a word sits in element i; unused tail bytes are zero.
  typedef logic [PREFIX_LEN-1:0][7:0] word_t;

  localparam word_t CMD_WORD [NUM_CMDS] = '{
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "q"},
    {8'h00, "a", "_", "q", "e", "r"},
    {8'h00, "s", "_", "q", "e", "r"},
    {8'h00, "l", "_", "q", "e", "r"},
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "a"},
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "s"},
    {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, "l"},
    {8'h00, 8'h00, 8'h00, "1", "i", "t"},
    {8'h00, 8'h00, 8'h00, "2", "i", "t"},
    {8'h00, 8'h00, 8'h00, "3", "i", "t"},
    {8'h00, 8'h00, 8'h00, "4", "i", "t"}
  };

  localparam logic [PREFIX_IDX_W-1:0] CMD_LEN [NUM_CMDS] = '{
    3'd1, 3'd5, 3'd5, 3'd5, 3'd1, 3'd1, 3'd1, 3'd3, 3'd3, 3'd3, 3'd3
  };

  localparam action_e CMD_ACTION [NUM_CMDS] = '{
    ACT_STOP_STREAM, ACT_SEND_ALL, ACT_SEND_SWITCH, ACT_SEND_LIGHT,
    ACT_START_STREAM, ACT_START_STREAM, ACT_START_STREAM,
    ACT_SET_INTERVAL, ACT_SET_INTERVAL, ACT_SET_INTERVAL, ACT_SET_INTERVAL
  };

  // Sensor choice for the start commands, interval index for the interval ones.
  localparam logic [1:0] CMD_ARG [NUM_CMDS] = '{
    2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3
  };

  typedef struct packed {
    logic        stream_on;
    logic [1:0]  sensor;
    logic [1:0]  interval;
  } settings_t;

  typedef struct packed {
    reply_kind_e reply_kind;
    action_e     action_code;
    settings_t   settings;
  } match_t;

  typedef struct packed {
    logic [7:0]  echo_byte;
    logic        frame_done;
    reply_kind_e reply_kind;
    action_e     action_code;
    settings_t   settings;
  } result_t;

endpackage

// ----- design/fcd_matcher.sv -----
// Compares the leading bytes of the frame text with the fixed command words.
// Depends on fcd_pkg.
module fcd_matcher (
  input  fcd_pkg::word_t     prefix_i,
  input  fcd_pkg::settings_t cur_i,
  output fcd_pkg::match_t    match_o
);

  logic [fcd_pkg::NUM_CMDS-1:0]  hit;
  logic [fcd_pkg::CMD_IDX_W-1:0] sel;
  logic                          found;
  fcd_pkg::action_e              act;

  // A word matches when every byte up to and including its terminator agrees.
  always_comb begin
    for (int c = 0; c < fcd_pkg::NUM_CMDS; c++) begin
      hit[c] = 1'b1;
      for (int i = 0; i < fcd_pkg::PREFIX_LEN; i++) begin
        if ((fcd_pkg::PREFIX_IDX_W'(i) <= fcd_pkg::CMD_LEN[c]) &&
            (prefix_i[i] != fcd_pkg::CMD_WORD[c][i])) begin
          hit[c] = 1'b0;
        end
      end
    end
  end

  // The earliest word in the list wins.
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int c = fcd_pkg::NUM_CMDS - 1; c >= 0; c--) begin
      if (hit[c]) begin
        found = 1'b1;
        sel   = fcd_pkg::CMD_IDX_W'(c);
      end
    end
  end

  always_comb begin
    act                  = found ? fcd_pkg::CMD_ACTION[sel] : fcd_pkg::ACT_NONE;
    match_o.reply_kind   = found ? fcd_pkg::REPLY_ACK : fcd_pkg::REPLY_NAK;
    match_o.action_code  = act;
    match_o.settings     = cur_i;
    unique case (act)
      fcd_pkg::ACT_STOP_STREAM: begin
        match_o.settings.stream_on = 1'b0;
      end
      fcd_pkg::ACT_START_STREAM: begin
        match_o.settings.stream_on = 1'b1;
        match_o.settings.sensor    = fcd_pkg::CMD_ARG[sel];
      end
      fcd_pkg::ACT_SET_INTERVAL: begin
        match_o.settings.interval = fcd_pkg::CMD_ARG[sel];
      end
      default: begin
        match_o.settings = cur_i;
      end
    endcase
  end

endmodule

// ----- design/fcd_frame_ctrl.sv -----
// Frame state, text prefix, fill count and the streaming settings; builds one
// result per byte. Depends on fcd_pkg and fcd_matcher.
module fcd_frame_ctrl #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  input  logic [7:0]       start_code_i,
  input  logic [7:0]       end_code_i,
  output fcd_pkg::result_t result_o
);

  localparam int unsigned CntW = $clog2(BUF_DEPTH + 1);

  logic               in_frame_q, in_frame_d;
  fcd_pkg::word_t     prefix_q, prefix_d;
  logic [CntW-1:0]    fill_q, fill_d;
  logic               ovf_q, ovf_d;
  fcd_pkg::settings_t set_q, set_d;
  fcd_pkg::match_t    match;

  fcd_matcher u_matcher (
    .prefix_i (prefix_q),
    .cur_i    (set_q),
    .match_o  (match)
  );

  always_comb begin
    in_frame_d = in_frame_q;
    prefix_d   = prefix_q;
    fill_d     = fill_q;
    ovf_d      = ovf_q;
    set_d      = set_q;
    result_o.echo_byte   = rx_byte_i;
    result_o.frame_done  = 1'b0;
    result_o.reply_kind  = fcd_pkg::REPLY_NONE;
    result_o.action_code = fcd_pkg::ACT_NONE;
    priority if (!in_frame_q) begin
      if (rx_byte_i == start_code_i) begin
        in_frame_d = 1'b1;
        prefix_d   = '0;
        fill_d     = '0;
        ovf_d      = 1'b0;
      end
    end else if (rx_byte_i == end_code_i) begin
      in_frame_d          = 1'b0;
      result_o.frame_done = 1'b1;
      if (ovf_q) begin
        result_o.reply_kind = fcd_pkg::REPLY_NAK;
      end else begin
        result_o.reply_kind  = match.reply_kind;
        result_o.action_code = match.action_code;
        set_d                = match.settings;
      end
      prefix_d = '0;
      fill_d   = '0;
      ovf_d    = 1'b0;
    end else begin
      if (fill_q < CntW'(BUF_DEPTH)) begin
        // Only the leading bytes are kept; the rest are counted.
        for (int i = 0; i < fcd_pkg::PREFIX_LEN; i++) begin
          if (fill_q == CntW'(i)) begin
            prefix_d[i] = rx_byte_i;
          end
        end
        fill_d = fill_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    result_o.settings = set_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      prefix_q   <= '0;
      fill_q     <= '0;
      ovf_q      <= 1'b0;
      set_q      <= '0;
    end else if (accept_i) begin
      in_frame_q <= in_frame_d;
      prefix_q   <= prefix_d;
      fill_q     <= fill_d;
      ovf_q      <= ovf_d;
      set_q      <= set_d;
    end
  end

endmodule

// ----- design/fcd_out_buf.sv -----
// Output register with a skid stage for the result items.
// Depends on fcd_pkg.
module fcd_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fcd_pkg::result_t data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fcd_pkg::result_t out_data_o
);

  logic             out_valid_q, skid_valid_q;
  fcd_pkg::result_t out_q, skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (push_i) begin
        if (out_valid_q && out_stall_i) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      if (out_valid_q && out_stall_i) begin
        skid_q <= data_i;
      end else begin
        out_q <= data_i;
      end
    end else if (!out_stall_i && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/framed_command_decoder_top.sv -----
// Throughput: one item per cycle while the skid stage is free; the frame state
// and the command match are settled in the accepting cycle and the result goes
// into the output register, or into the skid stage while the output is stalled.
// The skid stage lets one more item in while the output is stalled.
// Reset (asynchronous, active low) closes any frame, empties the text, clears
// the streaming settings and loads the default start and end codes.
module framed_command_decoder_top #(
  parameter int unsigned BUF_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // Received bytes
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // Result items
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] echo_byte_o,
  output logic       frame_done_o,
  output logic [1:0] reply_kind_o,
  output logic [2:0] action_code_o,
  output logic       stream_enabled_o,
  output logic [1:0] sensor_select_o,
  output logic [1:0] interval_select_o
);

  logic [7:0]       start_q, end_q;
  logic             accept;
  logic             buf_full;
  fcd_pkg::result_t result, out_data;

  // Configuration is always taken; indexes beyond the two registers are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= fcd_pkg::START_CODE_RST;
      end_q   <= fcd_pkg::END_CODE_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == fcd_pkg::REG_START_CODE) begin
        start_q <= cfg_data_i;
      end
      if (cfg_index_i == fcd_pkg::REG_END_CODE) begin
        end_q <= cfg_data_i;
      end
    end
  end

  // A byte is taken whenever the skid stage is free.
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  fcd_frame_ctrl #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_frame_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .rx_byte_i    (rx_byte_i),
    .start_code_i (start_q),
    .end_code_i   (end_q),
    .result_o     (result)
  );

  fcd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .data_i      (result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign echo_byte_o       = out_data.echo_byte;
  assign frame_done_o      = out_data.frame_done;
  assign reply_kind_o      = out_data.reply_kind;
  assign action_code_o     = out_data.action_code;
  assign stream_enabled_o  = out_data.settings.stream_on;
  assign sensor_select_o   = out_data.settings.sensor;
  assign interval_select_o = out_data.settings.interval;

  // A reply is given exactly when a frame closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_done_o == (reply_kind_o != fcd_pkg::REPLY_NONE)))
    else $error("reply kind disagrees with frame_done");

  // After an accepted byte the output register holds an item in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted item did not reach the output");

  // The skid stage is only used while the output register holds an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_full |-> out_valid_o)
    else $error("skid stage filled ahead of the output register");

  // A start command always leaves streaming enabled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_code_o == fcd_pkg::ACT_START_STREAM)) |-> stream_enabled_o)
    else $error("start command did not enable streaming");

endmodule
